### hw/rtl/visibility_edge_cost_assert.svh
// Assertion macros used by the checker file vec_chk.sv.
// Depends on nothing; expects clk_i and rst_ni in scope at the point of use.
`ifndef VISIBILITY_EDGE_COST_ASSERT_SVH
`define VISIBILITY_EDGE_COST_ASSERT_SVH

// clocked, disabled while in reset
`define VEC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("visibility_edge_cost check failed");

// clocked, also checked during reset
`define VEC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("visibility_edge_cost check failed");

`endif

### hw/rtl/vec_pkg.sv
// Types, constants and codes of the visibility edge cost block.
// No dependencies; used by the top level and its checker.
package vec_pkg;

  localparam int CoordBits  = 24;
  localparam int DiffW      = CoordBits + 1;
  localparam int ProdW      = 2 * DiffW;
  localparam int SqW        = ProdW + 1;
  localparam int SqrtIters  = (SqW + 1) / 2;
  localparam int PointDepth = 1024;
  localparam int PointAw    = $clog2(PointDepth);
  localparam int SegDepth   = 256;
  localparam int SegAw      = $clog2(SegDepth);
  localparam int SegCntW    = 9;
  localparam int PtCntW     = 11;
  localparam int CfgDataW   = 11;
  localparam int CostW      = 26;
  localparam int StepW      = 4;
  localparam int IterW      = $clog2(SqrtIters + 1);

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef enum logic [1:0] {
    ActPoint    = 2'd0,
    ActPassage  = 2'd1,
    ActObstacle = 2'd2,
    ActQuery    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    VerdClear    = 2'd0,
    VerdPassage  = 2'd1,
    VerdBlocked  = 2'd2,
    VerdBadIndex = 2'd3
  } verdict_e;

  typedef enum logic [1:0] {
    RegPointTotal    = 2'd0,
    RegPassageTotal  = 2'd1,
    RegObstacleTotal = 2'd2,
    RegUnused        = 2'd3
  } reg_index_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PA,
    S_PB,
    S_LEN,
    S_SQRT,
    S_NEXT,
    S_SEG
  } state_e;

  typedef struct packed {
    action_e              action;
    logic [PointAw-1:0]   slot;
    coord_t               first_x;
    coord_t               first_y;
    coord_t               second_x;
    coord_t               second_y;
    logic [PointAw-1:0]   end_a;
    logic [PointAw-1:0]   end_b;
  } req_t;

  typedef struct packed {
    logic [CostW-1:0] cost;
    logic             unreachable;
    verdict_e         verdict;
  } rsp_t;

endpackage

### hw/rtl/visibility_edge_cost.sv
// Visibility edge cost: point and segment stores, segment intersection and
// edge length on one shared multiplier and one square-root iteration unit.
// Depends on vec_pkg.
//
// Usage: an item is accepted when start is high and busy is low. Point,
// passage and obstacle writes complete in the accept cycle and give no
// result. A query gives one result, shown on rsp_o for exactly one cycle
// with result_valid_o high; the receiver cannot stall it.
// Configuration (point, passage and obstacle counts) is written on the
// cfg channel, always ready. The user must write it only while no query
// is in flight; the block itself does not enforce this.
// A bad index gives its result in the cycle after accept. Otherwise the
// query reads both points, forms the squared length (two products on the
// shared multiplier) and runs 26 square-root iterations, then tests each
// passage and then each obstacle segment (8 orientation products through
// the same multiplier, compare and box checks). The scan stops at the
// first hit.
// Reset clears the counts and control state; store contents are
// undefined until written.
module visibility_edge_cost (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  vec_pkg::req_t               req_i,
  output logic                        result_valid_o,
  output vec_pkg::rsp_t               rsp_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  vec_pkg::reg_index_e         cfg_index_i,
  input  logic [vec_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int CW = vec_pkg::CoordBits;
  localparam int DW = vec_pkg::DiffW;

  typedef logic signed [DW-1:0] diff_t;

  function automatic diff_t sub(input vec_pkg::coord_t a, input vec_pkg::coord_t b);
    sub = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
  endfunction

  function automatic logic in_box(input vec_pkg::coord_t ax, input vec_pkg::coord_t ay,
                                  input vec_pkg::coord_t bx, input vec_pkg::coord_t by,
                                  input vec_pkg::coord_t px, input vec_pkg::coord_t py);
    logic okx, oky;
    okx = (ax < bx) ? (px >= ax && px <= bx) : (px >= bx && px <= ax);
    oky = (ay < by) ? (py >= ay && py <= by) : (py >= by && py <= ay);
    in_box = okx && oky;
  endfunction

  // control
  vec_pkg::state_e state_q, state_d;
  logic [vec_pkg::StepW-1:0]   step_q;
  logic [vec_pkg::IterW-1:0]   iter_q;
  logic [vec_pkg::SegCntW-1:0] idx_q;
  logic                        obs_phase_q;
  logic                        res_valid_q;
  logic [vec_pkg::PtCntW-1:0]  pt_total_q;
  logic [vec_pkg::SegCntW-1:0] pas_total_q, obs_total_q;

  // payload
  vec_pkg::rsp_t               res_q;
  logic [vec_pkg::PointAw-1:0] ib_q;
  vec_pkg::coord_t             ax_q, ay_q, bx_q, by_q;
  diff_t                       op_a_q, op_b_q;
  logic signed [vec_pkg::ProdW-1:0] prod_q, p1_q;
  logic [1:0]                  sgn_q [4];
  logic [vec_pkg::SqW-1:0]     sq_q, v_q, r_q, bit_q;
  logic [vec_pkg::CostW-1:0]   len_q;

  // memories
  logic [2*CW-1:0] pt_mem  [vec_pkg::PointDepth];
  logic [4*CW-1:0] pas_mem [vec_pkg::SegDepth];
  logic [4*CW-1:0] obs_mem [vec_pkg::SegDepth];
  logic [2*CW-1:0] pt_rdata_q;
  logic [4*CW-1:0] pas_rdata_q, obs_rdata_q;
  logic [vec_pkg::PointAw-1:0] pt_raddr;

  logic accept, bad_idx, seg_end, hit, last_iter;
  logic [vec_pkg::SegCntW-1:0] seg_cnt;
  logic [4*CW-1:0] seg;
  vec_pkg::coord_t q1x, q1y, q2x, q2y;
  logic [vec_pkg::SqW-1:0] r_sum, r_next, v_next;
  logic signed [vec_pkg::ProdW-1:0] prod_d;
  logic [2:0] cons_j;
  logic [1:0] s1, s2, s3, s4;

  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign result_valid_o = res_valid_q;
  assign rsp_o       = res_q;

  assign bad_idx = ({1'b0, req_i.end_a} >= pt_total_q) || ({1'b0, req_i.end_b} >= pt_total_q);

  // active segment list
  always_comb begin
    if (obs_phase_q) begin
      seg_cnt = (obs_total_q > vec_pkg::SegCntW'(vec_pkg::SegDepth))
                ? vec_pkg::SegCntW'(vec_pkg::SegDepth) : obs_total_q;
      seg = obs_rdata_q;
    end else begin
      seg_cnt = (pas_total_q > vec_pkg::SegCntW'(vec_pkg::SegDepth))
                ? vec_pkg::SegCntW'(vec_pkg::SegDepth) : pas_total_q;
      seg = pas_rdata_q;
    end
  end
  assign seg_end = idx_q >= seg_cnt;
  assign q1x = seg[CW-1:0];
  assign q1y = seg[2*CW-1:CW];
  assign q2x = seg[3*CW-1:2*CW];
  assign q2y = seg[4*CW-1:3*CW];

  assign s1 = sgn_q[0];
  assign s2 = sgn_q[1];
  assign s3 = sgn_q[2];
  assign s4 = sgn_q[3];
  assign hit = (s1 != s2 && s3 != s4)
            || (s1 == 2'b00 && in_box(ax_q, ay_q, bx_q, by_q, q1x, q1y))
            || (s2 == 2'b00 && in_box(ax_q, ay_q, bx_q, by_q, q2x, q2y))
            || (s3 == 2'b00 && in_box(q1x, q1y, q2x, q2y, ax_q, ay_q))
            || (s4 == 2'b00 && in_box(q1x, q1y, q2x, q2y, bx_q, by_q));

  // square-root digit step
  assign r_sum     = r_q + bit_q;
  assign v_next    = (v_q >= r_sum) ? v_q - r_sum : v_q;
  assign r_next    = (v_q >= r_sum) ? (r_q >> 1) + bit_q : r_q >> 1;
  assign last_iter = iter_q == vec_pkg::IterW'(vec_pkg::SqrtIters - 1);

  assign prod_d = op_a_q * op_b_q;
  assign cons_j = 3'(step_q - vec_pkg::StepW'(2));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vec_pkg::S_IDLE: begin
        if (accept && req_i.action == vec_pkg::ActQuery && !bad_idx) state_d = vec_pkg::S_PA;
      end
      vec_pkg::S_PA:   state_d = vec_pkg::S_PB;
      vec_pkg::S_PB:   state_d = vec_pkg::S_LEN;
      vec_pkg::S_LEN: begin
        if (step_q == vec_pkg::StepW'(3)) state_d = vec_pkg::S_SQRT;
      end
      vec_pkg::S_SQRT: begin
        if (last_iter) state_d = vec_pkg::S_NEXT;
      end
      vec_pkg::S_NEXT: begin
        if (!seg_end) state_d = vec_pkg::S_SEG;
        else if (obs_phase_q) state_d = vec_pkg::S_IDLE;
      end
      vec_pkg::S_SEG: begin
        if (step_q == vec_pkg::StepW'(10)) state_d = hit ? vec_pkg::S_IDLE : vec_pkg::S_NEXT;
      end
      default: state_d = vec_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy     = 1'b1;
    pt_raddr = ib_q;
    unique case (state_q)
      vec_pkg::S_IDLE: begin
        busy     = 1'b0;
        pt_raddr = req_i.end_a;
      end
      default: begin
        busy     = 1'b1;
        pt_raddr = ib_q;
      end
    endcase
  end

  // stores
  always_ff @(posedge clk_i) begin
    if (accept && req_i.action == vec_pkg::ActPoint) begin
      pt_mem[req_i.slot] <= {req_i.first_y, req_i.first_x};
    end
    pt_rdata_q <= pt_mem[pt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (accept && req_i.action == vec_pkg::ActPassage && 32'(req_i.slot) < vec_pkg::SegDepth) begin
      pas_mem[req_i.slot[vec_pkg::SegAw-1:0]] <=
        {req_i.second_y, req_i.second_x, req_i.first_y, req_i.first_x};
    end
    pas_rdata_q <= pas_mem[idx_q[vec_pkg::SegAw-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (accept && req_i.action == vec_pkg::ActObstacle && 32'(req_i.slot) < vec_pkg::SegDepth) begin
      obs_mem[req_i.slot[vec_pkg::SegAw-1:0]] <=
        {req_i.second_y, req_i.second_x, req_i.first_y, req_i.first_x};
    end
    obs_rdata_q <= obs_mem[idx_q[vec_pkg::SegAw-1:0]];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vec_pkg::S_IDLE;
      step_q      <= '0;
      iter_q      <= '0;
      idx_q       <= '0;
      obs_phase_q <= 1'b0;
      res_valid_q <= 1'b0;
      pt_total_q  <= '0;
      pas_total_q <= '0;
      obs_total_q <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= 1'b0;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          vec_pkg::RegPointTotal:    pt_total_q  <= cfg_data_i[vec_pkg::PtCntW-1:0];
          vec_pkg::RegPassageTotal:  pas_total_q <= cfg_data_i[vec_pkg::SegCntW-1:0];
          vec_pkg::RegObstacleTotal: obs_total_q <= cfg_data_i[vec_pkg::SegCntW-1:0];
          default: ;
        endcase
      end
      if (state_q == vec_pkg::S_LEN || state_q == vec_pkg::S_SEG) begin
        step_q <= step_q + vec_pkg::StepW'(1);
      end else step_q <= '0;
      if (state_q == vec_pkg::S_SQRT) iter_q <= iter_q + vec_pkg::IterW'(1);
      else iter_q <= '0;
      if (state_q == vec_pkg::S_IDLE && accept && req_i.action == vec_pkg::ActQuery && bad_idx) begin
        res_valid_q <= 1'b1;
      end
      if (state_q == vec_pkg::S_LEN) begin
        idx_q       <= '0;
        obs_phase_q <= 1'b0;
      end
      if (state_q == vec_pkg::S_NEXT && seg_end) begin
        if (obs_phase_q) res_valid_q <= 1'b1;
        else begin
          obs_phase_q <= 1'b1;
          idx_q       <= '0;
        end
      end
      if (state_q == vec_pkg::S_SEG && step_q == vec_pkg::StepW'(10)) begin
        if (hit) res_valid_q <= 1'b1;
        else idx_q <= idx_q + vec_pkg::SegCntW'(1);
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    unique case (state_q)
      vec_pkg::S_IDLE: begin
        ib_q <= req_i.end_b;
        res_q.cost        <= '0;
        res_q.unreachable <= 1'b1;
        res_q.verdict     <= vec_pkg::VerdBadIndex;
      end
      vec_pkg::S_PA: begin
        ax_q <= pt_rdata_q[CW-1:0];
        ay_q <= pt_rdata_q[2*CW-1:CW];
      end
      vec_pkg::S_PB: begin
        bx_q <= pt_rdata_q[CW-1:0];
        by_q <= pt_rdata_q[2*CW-1:CW];
      end
      vec_pkg::S_LEN: begin
        // dx*dx then dy*dy on the shared multiplier
        if (step_q == vec_pkg::StepW'(0)) begin
          op_a_q <= sub(ax_q, bx_q);
          op_b_q <= sub(ax_q, bx_q);
        end else if (step_q == vec_pkg::StepW'(1)) begin
          op_a_q <= sub(ay_q, by_q);
          op_b_q <= sub(ay_q, by_q);
        end
        if (step_q == vec_pkg::StepW'(2)) sq_q <= {1'b0, prod_q};
        if (step_q == vec_pkg::StepW'(3)) begin
          v_q   <= sq_q + {1'b0, prod_q};
          r_q   <= '0;
          bit_q <= vec_pkg::SqW'(1) << (2 * (vec_pkg::SqrtIters - 1));
        end
      end
      vec_pkg::S_SQRT: begin
        v_q   <= v_next;
        r_q   <= r_next;
        bit_q <= bit_q >> 2;
        if (last_iter) begin
          len_q <= (r_next > vec_pkg::SqW'({vec_pkg::CostW{1'b1}}))
                   ? {vec_pkg::CostW{1'b1}} : r_next[vec_pkg::CostW-1:0];
          // fallback result when no segment is hit
          res_q.cost        <= (r_next > vec_pkg::SqW'({vec_pkg::CostW{1'b1}}))
                               ? {vec_pkg::CostW{1'b1}} : r_next[vec_pkg::CostW-1:0];
          res_q.unreachable <= 1'b0;
          res_q.verdict     <= vec_pkg::VerdClear;
        end
      end
      vec_pkg::S_NEXT: ;
      vec_pkg::S_SEG: begin
        case (step_q[2:0])
          3'd0: begin op_a_q <= sub(bx_q, ax_q); op_b_q <= sub(q1y, ay_q); end
          3'd1: begin op_a_q <= sub(by_q, ay_q); op_b_q <= sub(q1x, ax_q); end
          3'd2: begin op_a_q <= sub(bx_q, ax_q); op_b_q <= sub(q2y, ay_q); end
          3'd3: begin op_a_q <= sub(by_q, ay_q); op_b_q <= sub(q2x, ax_q); end
          3'd4: begin op_a_q <= sub(q2x, q1x);   op_b_q <= sub(ay_q, q1y); end
          3'd5: begin op_a_q <= sub(q2y, q1y);   op_b_q <= sub(ax_q, q1x); end
          3'd6: begin op_a_q <= sub(q2x, q1x);   op_b_q <= sub(by_q, q1y); end
          default: begin op_a_q <= sub(q2y, q1y); op_b_q <= sub(bx_q, q1x); end
        endcase
        if (step_q >= vec_pkg::StepW'(2) && step_q <= vec_pkg::StepW'(9)) begin
          if (!cons_j[0]) p1_q <= prod_q;
          else sgn_q[cons_j[2:1]] <= {p1_q > prod_q, p1_q < prod_q};
        end
        if (step_q == vec_pkg::StepW'(10) && hit) begin
          if (obs_phase_q) begin
            res_q.cost        <= '0;
            res_q.unreachable <= 1'b1;
            res_q.verdict     <= vec_pkg::VerdBlocked;
          end else begin
            res_q.cost        <= len_q;
            res_q.unreachable <= 1'b0;
            res_q.verdict     <= vec_pkg::VerdPassage;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

### hw/rtl/vec_chk.sv
// Port-level checker for visibility_edge_cost, bound to the top level.
// Depends on vec_pkg and visibility_edge_cost_assert.svh.
`include "visibility_edge_cost_assert.svh"

module vec_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input vec_pkg::req_t req_i,
  input logic          result_valid_o,
  input vec_pkg::rsp_t rsp_o
);

  // unreachable exactly for blocked edges and bad indices
  `VEC_ASSERT(a_unreach_verdict, result_valid_o |-> (rsp_o.unreachable == (rsp_o.verdict == vec_pkg::VerdBlocked || rsp_o.verdict == vec_pkg::VerdBadIndex)))

  // an unreachable result carries no cost
  `VEC_ASSERT(a_unreach_cost, result_valid_o && rsp_o.unreachable |-> rsp_o.cost == '0)

  // store writes never produce a result transfer
  `VEC_ASSERT(a_write_silent, start && !busy && req_i.action != vec_pkg::ActQuery |=> !result_valid_o)

  // a result right after an idle accept can only be a bad index
  `VEC_ASSERT_ALWAYS(a_fast_bad, rst_ni && $past(rst_ni) && result_valid_o && !$past(busy) && !busy |-> rsp_o.verdict == vec_pkg::VerdBadIndex)

endmodule

bind visibility_edge_cost vec_chk u_vec_chk (.*);

### test/tb_visibility_edge_cost.sv
// Self-checking testbench of visibility_edge_cost: loads, edge queries, count settings.
// Depends on vec_pkg and the visibility_edge_cost top level; stands alone.
`timescale 1ns / 1ps

module tb_visibility_edge_cost;
  import vec_pkg::*;

  typedef struct {
    longint x;
    longint y;
  } xy_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  req_t req = '0;
  logic result_valid_o;
  rsp_t rsp_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  reg_index_e cfg_index_i = RegPointTotal;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  visibility_edge_cost DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start_i),
    .busy           (busy_o),
    .req_i          (req),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  req_t cmd_queue[$];
  rsp_t pending_costs[$];
  int   fails = 0;
  int   accepted = 0;
  int   stall_cycles = 0;
  bit   hold_off = 1'b0;

  // shadow stores and counts
  xy_t pts[PointDepth];
  bit  pt_written[PointDepth];
  xy_t pas_s[SegDepth], pas_e[SegDepth], obs_s[SegDepth], obs_e[SegDepth];
  int  pt_cnt = 0, pas_cnt = 0, obs_cnt = 0;

  function automatic int orient(xy_t a, xy_t b, xy_t c);
    longint p1, p2;
    p1 = (b.x - a.x) * (c.y - a.y);
    p2 = (b.y - a.y) * (c.x - a.x);
    return (p1 > p2) ? 1 : ((p1 < p2) ? -1 : 0);
  endfunction

  function automatic bit in_box(xy_t a, xy_t b, xy_t p);
    longint lx, hx, ly, hy;
    lx = (a.x < b.x) ? a.x : b.x;
    hx = (a.x < b.x) ? b.x : a.x;
    ly = (a.y < b.y) ? a.y : b.y;
    hy = (a.y < b.y) ? b.y : a.y;
    return p.x >= lx && p.x <= hx && p.y >= ly && p.y <= hy;
  endfunction

  function automatic bit crosses(xy_t a1, xy_t a2, xy_t b1, xy_t b2);
    int s1, s2, s3, s4;
    s1 = orient(a1, a2, b1);
    s2 = orient(a1, a2, b2);
    s3 = orient(b1, b2, a1);
    s4 = orient(b1, b2, a2);
    if (s1 != s2 && s3 != s4) return 1'b1;
    if (s1 == 0 && in_box(a1, a2, b1)) return 1'b1;
    if (s2 == 0 && in_box(a1, a2, b2)) return 1'b1;
    if (s3 == 0 && in_box(b1, b2, a1)) return 1'b1;
    if (s4 == 0 && in_box(b1, b2, a2)) return 1'b1;
    return 1'b0;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic int clamp(int v, int hi);
    return (v > hi) ? hi : v;
  endfunction

  // apply one accepted item to the shadow state, queue its result if any
  function automatic void edge_cost_predict(req_t r);
    xy_t p, q, a, b;
    longint dx, dy;
    longint unsigned len;
    bit hit_pas, hit_obs;
    rsp_t e;
    int n;
    p.x = longint'(r.first_x);
    p.y = longint'(r.first_y);
    q.x = longint'(r.second_x);
    q.y = longint'(r.second_y);
    case (r.action)
      ActPoint: begin
        pts[r.slot] = p;
        pt_written[r.slot] = 1'b1;
      end
      ActPassage: if (r.slot < SegDepth) begin
        pas_s[r.slot] = p;
        pas_e[r.slot] = q;
      end
      ActObstacle: if (r.slot < SegDepth) begin
        obs_s[r.slot] = p;
        obs_e[r.slot] = q;
      end
      default: begin
        n = clamp(pt_cnt, PointDepth);
        if (r.end_a >= n || r.end_b >= n) begin
          e.cost = '0;
          e.unreachable = 1'b1;
          e.verdict = VerdBadIndex;
        end else begin
          a = pts[r.end_a];
          b = pts[r.end_b];
          dx = a.x - b.x;
          dy = a.y - b.y;
          len = int_sqrt(dx * dx + dy * dy);
          if (len > 67108863) len = 67108863;
          hit_pas = 1'b0;
          hit_obs = 1'b0;
          for (int i = 0; i < clamp(pas_cnt, SegDepth); i++)
            if (crosses(a, b, pas_s[i], pas_e[i])) hit_pas = 1'b1;
          for (int i = 0; i < clamp(obs_cnt, SegDepth); i++)
            if (crosses(a, b, obs_s[i], obs_e[i])) hit_obs = 1'b1;
          e.cost = len[CostW-1:0];
          e.unreachable = 1'b0;
          e.verdict = hit_pas ? VerdPassage : VerdClear;
          if (!hit_pas && hit_obs) begin
            e.cost = '0;
            e.unreachable = 1'b1;
            e.verdict = VerdBlocked;
          end
        end
        pending_costs.push_back(e);
      end
    endcase
  endfunction

  // driver: start stays high until the transfer happens
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        edge_cost_predict(req);
        accepted++;
      end
      if (!(start_i && busy_o)) begin
        if (cmd_queue.size() != 0 && !hold_off &&
            ((accepted > 300 && accepted < 500) || $urandom_range(99) >= 28)) begin
          req <= cmd_queue.pop_front();
          start_i <= 1'b1;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && result_valid_o) begin
      if (pending_costs.size() == 0) begin
        $error("unexpected result cost %0d verdict %0d", rsp_o.cost, rsp_o.verdict);
        fails++;
      end else begin
        e = pending_costs.pop_front();
        if (rsp_o.cost !== e.cost) begin
          $error("cost exp %0d got %0d", e.cost, rsp_o.cost);
          fails++;
        end
        if (rsp_o.unreachable !== e.unreachable) begin
          $error("unreachable exp %0d got %0d", e.unreachable, rsp_o.unreachable);
          fails++;
        end
        if (rsp_o.verdict !== e.verdict) begin
          $error("verdict exp %0d got %0d", e.verdict, rsp_o.verdict);
          fails++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || result_valid_o || (cfg_valid_i && cfg_ready_o))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= 60000) begin
        $display("tb_visibility_edge_cost NOT OK");
        $finish;
      end
    end
  end

  function automatic int rand_coord();
    case ($urandom_range(9))
      0: return int'($urandom);
      1, 2, 3, 4, 5: return (int'($urandom_range(16)) - 8) * 256;
      default: return int'($urandom_range(8000)) - 4000;
    endcase
  endfunction

  function automatic req_t mk_write(action_e act, int slot, int x1, int y1, int x2, int y2);
    req_t r;
    r = '0;
    r.end_a = PointAw'($urandom);
    r.end_b = PointAw'($urandom);
    r.action = act;
    r.slot = PointAw'(slot);
    r.first_x = coord_t'(x1);
    r.first_y = coord_t'(y1);
    r.second_x = coord_t'(x2);
    r.second_y = coord_t'(y2);
    return r;
  endfunction

  function automatic req_t mk_query(int ia, int ib);
    req_t r;
    r = '0;
    r.slot = PointAw'($urandom);
    r.first_x = coord_t'($urandom);
    r.second_y = coord_t'($urandom);
    r.action = ActQuery;
    r.end_a = PointAw'(ia);
    r.end_b = PointAw'(ib);
    return r;
  endfunction

  function automatic req_t rand_seg(action_e act, int prefix);
    int x, y, slot;
    slot = ($urandom_range(9) == 0) ? int'($urandom_range(1023, SegDepth))
                                    : int'($urandom_range(prefix - 1));
    x = rand_coord();
    y = rand_coord();
    // degenerate segment now and then
    if ($urandom_range(7) == 0) return mk_write(act, slot, x, y, x, y);
    return mk_write(act, slot, x, y, rand_coord(), rand_coord());
  endfunction

  function automatic int pick_point();
    int n, k;
    n = clamp(pt_cnt, PointDepth);
    if (n == 0 || $urandom_range(9) == 0) begin
      k = int'($urandom_range(1023));
      if (k >= n || pt_written[k]) return k;
    end
    // in-range picks only land on points already written
    do k = int'($urandom_range(n - 1)); while (!pt_written[k]);
    return k;
  endfunction

  task automatic drain();
    do @(negedge clk_i);
    while (cmd_queue.size() != 0 || start_i || busy_o || pending_costs.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(reg_index_e idx, int value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= CfgDataW'(value);
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    case (idx)
      RegPointTotal:    pt_cnt = value;
      RegPassageTotal:  pas_cnt = value;
      RegObstacleTotal: obs_cnt = value;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_counts(int np, int npas, int nobs);
    cfg_write(RegPointTotal, np);
    cfg_write(RegPassageTotal, npas);
    cfg_write(RegObstacleTotal, nobs);
  endtask

  task automatic push_random(int n, int pfx_pt, int pfx_seg);
    int roll;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(9);
      if (roll < 6)
        cmd_queue.push_back(mk_query(pick_point(), pick_point()));
      else if (roll < 8)
        cmd_queue.push_back(mk_write(ActPoint, $urandom_range(pfx_pt - 1),
                                     rand_coord(), rand_coord(), $urandom, $urandom));
      else if (roll == 8)
        cmd_queue.push_back(rand_seg(ActPassage, pfx_seg));
      else
        cmd_queue.push_back(rand_seg(ActObstacle, pfx_seg));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_counts(0, 0, 0);
    cmd_queue.push_back(mk_query(0, 0));
    drain();

    // directed loads: extremes, a degenerate passage, a touching passage
    cmd_queue.push_back(mk_write(ActPoint, 0, 0, 0, 0, 0));
    cmd_queue.push_back(mk_write(ActPoint, 1, 2048, 0, -1, -1));
    cmd_queue.push_back(mk_write(ActPoint, 2, 0, 2048, 0, 0));
    cmd_queue.push_back(mk_write(ActPoint, 3, 2048, 2048, 0, 0));
    cmd_queue.push_back(mk_write(ActPoint, 4, -8388608, -8388608, 0, 0));
    cmd_queue.push_back(mk_write(ActPoint, 5, 8388607, 8388607, 0, 0));
    for (int i = 6; i < 64; i++)
      cmd_queue.push_back(mk_write(ActPoint, i, rand_coord(), rand_coord(), 0, 0));
    cmd_queue.push_back(mk_write(ActPassage, 0, 1024, 0, 1024, 0));
    cmd_queue.push_back(mk_write(ActPassage, 1, 2048, 0, 4096, 0));
    cmd_queue.push_back(mk_write(ActObstacle, 0, 1024, -1024, 1024, 1024));
    cmd_queue.push_back(mk_write(ActObstacle, 1, 0, 4096, 0, 2048));
    for (int i = 2; i < 16; i++) begin
      cmd_queue.push_back(mk_write(ActPassage, i, rand_coord(), rand_coord(),
                                   rand_coord(), rand_coord()));
      cmd_queue.push_back(mk_write(ActObstacle, i, rand_coord(), rand_coord(),
                                   rand_coord(), rand_coord()));
    end
    cmd_queue.push_back(mk_write(ActPassage, 300, 0, 0, 2048, 0));
    drain();

    set_counts(64, 0, 0);
    cmd_queue.push_back(mk_query(0, 1));
    cmd_queue.push_back(mk_query(4, 5));
    cmd_queue.push_back(mk_query(5, 4));
    cmd_queue.push_back(mk_query(2, 2));
    cmd_queue.push_back(mk_query(63, 64));
    cmd_queue.push_back(mk_query(1023, 0));
    drain();
    set_counts(64, 0, 2);
    cmd_queue.push_back(mk_query(0, 1));  // blocked
    cmd_queue.push_back(mk_query(0, 2));  // touches obstacle end
    cmd_queue.push_back(mk_query(1, 3));
    drain();
    set_counts(64, 2, 2);
    cmd_queue.push_back(mk_query(0, 1));  // degenerate passage on the edge
    cmd_queue.push_back(mk_query(1, 3));  // passage touches at endpoint
    cmd_queue.push_back(mk_query(2, 3));
    drain();
    cfg_write(RegUnused, 2047);
    cmd_queue.push_back(mk_query(0, 1));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_counts(0, 16, 16);
        1: set_counts(64, 16, 0);
        2: set_counts(1, 0, 16);
        default: set_counts($urandom_range(64), $urandom_range(16), $urandom_range(16));
      endcase
      push_random(30, 64, 16);
      if (ph == 3) begin
        // hold the sender until every result is back
        hold_off = 1'b1;
        while (pending_costs.size() != 0 || start_i) @(posedge clk_i);
        repeat (20) @(posedge clk_i);
        hold_off = 1'b0;
      end
      push_random(30, 64, 16);
      drain();
    end

    // top point slots and full segment stores, then counts above depth and at depth
    for (int i = PointDepth - 8; i < PointDepth; i++)
      cmd_queue.push_back(mk_write(ActPoint, i, rand_coord(), rand_coord(), 0, 0));
    for (int i = 0; i < SegDepth; i++) begin
      cmd_queue.push_back(mk_write(ActPassage, i, rand_coord(), rand_coord(),
                                   rand_coord(), rand_coord()));
      cmd_queue.push_back(mk_write(ActObstacle, i, rand_coord(), rand_coord(),
                                   rand_coord(), rand_coord()));
    end
    drain();
    set_counts(2047, 511, 511);
    for (int i = 0; i < 4; i++) cmd_queue.push_back(mk_query(pick_point(), pick_point()));
    cmd_queue.push_back(mk_query(1023, 1022));
    drain();
    set_counts(1024, 0, 256);
    for (int i = 0; i < 4; i++) cmd_queue.push_back(mk_query(pick_point(), pick_point()));
    drain();
    set_counts(1024, 256, 0);
    push_random(40, PointDepth, SegDepth);
    drain();

    repeat (50) @(posedge clk_i);
    if (fails == 0) begin
      $display("tb_visibility_edge_cost OK");
    end else begin
      $display("tb_visibility_edge_cost NOT OK");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/vec_pkg.sv
hw/rtl/visibility_edge_cost.sv
hw/rtl/vec_chk.sv
test/tb_visibility_edge_cost.sv
